// ===== hw/rtl/attitude_complementary_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Attitude filter assertion macros
// Clocked property checks, with and without reset qualification, shared by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef ATTITUDE_COMPLEMENTARY_FILTER_ASSERT_SVH
`define ATTITUDE_COMPLEMENTARY_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ACF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("attitude filter check failed");
`define ACF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("attitude filter check failed");
`else
`define ACF_ASSERT(lbl, prop)
`define ACF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hw/rtl/acf_pkg.sv =====
// ----------------------------------------------------------------------------
// Attitude filter package
// Sequencer states, angle constants, CORDIC arctangent table and wrap helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_ROLL,
    ST_PITCH,
    ST_BLEND,
    ST_OUTP
  } acf_state_e;

  // register indexes on the config port
  localparam logic [7:0] REG_BIAS_X = 8'd0;
  localparam logic [7:0] REG_BIAS_Y = 8'd1;
  localparam logic [7:0] REG_BIAS_Z = 8'd2;
  localparam logic [7:0] REG_WEIGHT = 8'd3;

  // angles in 1/32768 degree
  localparam logic signed [25:0] HalfTurn    = 26'sd5898240;
  localparam logic signed [25:0] FullTurn    = 26'sd11796480;
  localparam logic signed [24:0] QuarterTurn = 25'sd2949120;
  localparam logic [37:0]        DivRound    = 38'd7812;
  // ceil(2^52 / 15625), exact floor quotient for dividends below 2^38
  localparam logic [38:0]        RecipConst  = 39'd288230376152;
  localparam logic [16:0]        UnitWeight  = 17'd32768;
  localparam int unsigned        TabLen      = 24;

  function automatic logic [20:0] acf_atan(input logic [4:0] idx);
    logic [20:0] v;
    unique case (idx)
      5'd0:  v = 21'd1474560;
      5'd1:  v = 21'd870484;
      5'd2:  v = 21'd459940;
      5'd3:  v = 21'd233473;
      5'd4:  v = 21'd117189;
      5'd5:  v = 21'd58652;
      5'd6:  v = 21'd29333;
      5'd7:  v = 21'd14667;
      5'd8:  v = 21'd7334;
      5'd9:  v = 21'd3667;
      5'd10: v = 21'd1833;
      5'd11: v = 21'd917;
      5'd12: v = 21'd458;
      5'd13: v = 21'd229;
      5'd14: v = 21'd115;
      5'd15: v = 21'd57;
      5'd16: v = 21'd29;
      5'd17: v = 21'd14;
      5'd18: v = 21'd7;
      5'd19: v = 21'd4;
      5'd20: v = 21'd2;
      5'd21: v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

  // one correction of a full turn when outside +-180 degrees
  function automatic logic signed [23:0] acf_wrap(input logic signed [25:0] a);
    logic signed [25:0] r;
    if (a > HalfTurn) begin
      r = a - FullTurn;
    end else if (a < -HalfTurn) begin
      r = a + FullTurn;
    end else begin
      r = a;
    end
    return r[23:0];
  endfunction

endpackage

// ===== hw/rtl/attitude_complementary_filter.sv =====
// ----------------------------------------------------------------------------
// Attitude complementary filter
// Gyro integration with accelerometer roll/pitch correction, angle wrap.
// ----------------------------------------------------------------------------
// Each accepted word passes the states SQRT, ROLL, PITCH, BLEND and OUTP in order;
// a new word is taken only back in IDLE, so words do not overlap. The 16-step
// square root and the shared CORDIC unit, used for roll then pitch, set the pace.
// Rate scaling runs alongside the square root.
// Reset: angles clear to zero, biases to 0/0/26, weight to 29491 (0.9).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "attitude_complementary_filter_assert.svh"

module attitude_complementary_filter #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, step_time
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // roll_out, pitch_out, yaw_out
  output logic [47:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_addr_i,
  input  logic [15:0]  cfg_data_i
);

  acf_pkg::acf_state_e state_q, state_d;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // config
  logic signed [15:0] bias_q [3];
  logic [15:0]        weight_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q[0] <= 16'sd0;
      bias_q[1] <= 16'sd0;
      bias_q[2] <= 16'sd26;
      weight_q  <= 16'd29491;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        acf_pkg::REG_BIAS_X: bias_q[0] <= cfg_data_i;
        acf_pkg::REG_BIAS_Y: bias_q[1] <= cfg_data_i;
        acf_pkg::REG_BIAS_Z: bias_q[2] <= cfg_data_i;
        acf_pkg::REG_WEIGHT: weight_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input fields
  logic signed [15:0] rate   [3];
  logic signed [15:0] acc_x, acc_y, acc_z;
  logic [15:0]        dt;

  assign rate[0] = s_axis_tdata[15:0];
  assign rate[1] = s_axis_tdata[31:16];
  assign rate[2] = s_axis_tdata[47:32];
  assign acc_x   = s_axis_tdata[63:48];
  assign acc_y   = s_axis_tdata[79:64];
  assign acc_z   = s_axis_tdata[95:80];
  assign dt      = s_axis_tdata[111:96];

  // rate scaling: (|(rate - bias) * dt| * 32 + 7812) / 15625 by reciprocal;
  // one 19 x 39 multiplier, low half then high half of each lane
  logic signed [16:0] diff [3];
  logic signed [33:0] prod [3];
  logic [33:0]        mag  [3];
  logic [37:0]        dvd  [3];
  logic [37:0]        dvd_q[3];
  logic [23:0]        quo_q[3];
  logic               neg_q[3];
  logic [2:0]         div_idx_q;
  logic               div_busy_q;
  logic [37:0]        div_n;
  logic [18:0]        div_a;
  logic [57:0]        div_prod;
  logic [58:0]        div_sum;
  logic [38:0]        div_lo_q;
  logic signed [25:0] inc  [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      diff[l] = 17'(rate[l]) - 17'(bias_q[l]);
      prod[l] = diff[l] * $signed({1'b0, dt});
      mag[l]  = prod[l][33] ? 34'(-prod[l]) : 34'(prod[l]);
      dvd[l]  = {mag[l][31:0], 5'd0} + acf_pkg::DivRound;
      inc[l]  = neg_q[l] ? -$signed({2'b00, quo_q[l]}) : $signed({2'b00, quo_q[l]});
    end
    unique case (div_idx_q[2:1])
      2'd0:    div_n = dvd_q[0];
      2'd1:    div_n = dvd_q[1];
      default: div_n = dvd_q[2];
    endcase
    div_a    = div_idx_q[0] ? div_n[37:19] : div_n[18:0];
    div_prod = div_a * acf_pkg::RecipConst;
    // high partial plus low partial already shifted down by 19
    div_sum  = {1'b0, div_prod} + {20'd0, div_lo_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_idx_q  <= '0;
      div_busy_q <= 1'b0;
    end else if (accept) begin
      div_idx_q  <= '0;
      div_busy_q <= 1'b1;
    end else if (div_busy_q) begin
      if (div_idx_q == 3'd5) begin
        div_idx_q  <= '0;
        div_busy_q <= 1'b0;
      end else begin
        div_idx_q <= div_idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int l = 0; l < 3; l++) begin
        dvd_q[l] <= dvd[l];
        neg_q[l] <= prod[l][33];
      end
    end else if (div_busy_q) begin
      if (!div_idx_q[0]) begin
        div_lo_q <= div_prod[57:19];
      end else begin
        for (int l = 0; l < 3; l++) begin
          if (div_idx_q[2:1] == 2'(l)) begin
            quo_q[l] <= div_sum[56:33];
          end
        end
      end
    end
  end

  // square root of ay^2 + az^2, two bits a cycle
  logic [31:0] sq_v_q, sq_r_q, sq_bit_q;
  logic [3:0]  sq_cnt_q;
  logic [32:0] sq_try;
  logic        sq_ge;
  logic signed [31:0] sq_y, sq_z;
  logic signed [15:0] acc_x_q, acc_y_q, acc_z_q;

  assign sq_y   = acc_y * acc_y;
  assign sq_z   = acc_z * acc_z;
  assign sq_try = {1'b0, sq_r_q} + {1'b0, sq_bit_q};
  assign sq_ge  = {1'b0, sq_v_q} >= sq_try;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_v_q   <= 32'(sq_y) + 32'(sq_z);
      sq_r_q   <= '0;
      sq_bit_q <= 32'h4000_0000;
      acc_x_q  <= acc_x;
      acc_y_q  <= acc_y;
      acc_z_q  <= acc_z;
    end else if (state_q == acf_pkg::ST_SQRT) begin
      if (sq_ge) begin
        sq_v_q <= 32'({1'b0, sq_v_q} - sq_try);
        sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
    end else if (accept) begin
      sq_cnt_q <= '0;
    end else if (state_q == acf_pkg::ST_SQRT) begin
      sq_cnt_q <= sq_cnt_q + 4'd1;
    end
  end

  // shared CORDIC: roll first, then pitch
  logic               cstart_q, cdone;
  logic signed [16:0] cy, cx;
  logic signed [24:0] cangle;
  logic signed [24:0] acc_roll_q, acc_pitch_q;

  acf_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cstart_q),
    .y_i    (cy),
    .x_i    (cx),
    .done_o (cdone),
    .angle_o(cangle)
  );

  // blend and wrap
  logic signed [23:0] angle_q [3];
  logic [2:0]         bl_q;
  logic signed [43:0] mul_q, sum_q, bl_sum;
  logic signed [25:0] gyro_ang, bl_res;
  logic signed [24:0] bl_acc;
  logic [16:0]        alpha, beta;

  assign alpha  = (weight_q > 16'd32768) ? acf_pkg::UnitWeight : {1'b0, weight_q};
  assign beta   = acf_pkg::UnitWeight - alpha;
  assign bl_sum = (sum_q + 44'sd16384) >>> 15;
  assign bl_res = bl_sum[25:0];

  // output register
  logic        mval_q;
  logic [47:0] mdata_q;
  logic        out_load;

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdata_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acf_pkg::ST_IDLE:  if (accept) state_d = acf_pkg::ST_SQRT;
      acf_pkg::ST_SQRT:  if (sq_cnt_q == 4'd15) state_d = acf_pkg::ST_ROLL;
      acf_pkg::ST_ROLL:  if (cdone) state_d = acf_pkg::ST_PITCH;
      acf_pkg::ST_PITCH: if (cdone) state_d = acf_pkg::ST_BLEND;
      acf_pkg::ST_BLEND: if (bl_q == 3'd4) state_d = acf_pkg::ST_OUTP;
      acf_pkg::ST_OUTP:  if (!mval_q || m_axis_tready) state_d = acf_pkg::ST_IDLE;
      default:           state_d = acf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == acf_pkg::ST_IDLE);
    out_load      = (state_q == acf_pkg::ST_OUTP) && (!mval_q || m_axis_tready);
    if (state_q == acf_pkg::ST_PITCH) begin
      cy = -17'(acc_x_q);
      cx = {1'b0, sq_r_q[15:0]};
    end else begin
      cy = 17'(acc_y_q);
      cx = 17'(acc_z_q);
    end
    unique case (bl_q)
      3'd0, 3'd1: begin
        gyro_ang = 26'(angle_q[0]) + inc[0];
        bl_acc   = acc_roll_q;
      end
      default: begin
        gyro_ang = 26'(angle_q[1]) + inc[1];
        bl_acc   = acc_pitch_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= acf_pkg::ST_IDLE;
      cstart_q <= 1'b0;
      bl_q     <= '0;
      mval_q   <= 1'b0;
      angle_q[0] <= '0;
      angle_q[1] <= '0;
      angle_q[2] <= '0;
    end else begin
      state_q  <= state_d;
      cstart_q <= ((state_q == acf_pkg::ST_SQRT) && (sq_cnt_q == 4'd15)) ||
                  ((state_q == acf_pkg::ST_ROLL) && cdone);
      if (state_q == acf_pkg::ST_BLEND) begin
        bl_q <= bl_q + 3'd1;
        if (bl_q == 3'd2) begin
          angle_q[0] <= acf_pkg::acf_wrap(bl_res);
        end
        if (bl_q == 3'd4) begin
          angle_q[1] <= acf_pkg::acf_wrap(bl_res);
          angle_q[2] <= acf_pkg::acf_wrap(26'(angle_q[2]) + inc[2]);
        end
      end else begin
        bl_q <= '0;
      end
      if (out_load) begin
        mval_q <= 1'b1;
      end else if (m_axis_tready) begin
        mval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cdone && (state_q == acf_pkg::ST_ROLL)) begin
      acc_roll_q <= cangle;
    end
    if (cdone && (state_q == acf_pkg::ST_PITCH)) begin
      acc_pitch_q <= cangle;
    end
    if (state_q == acf_pkg::ST_BLEND) begin
      unique case (bl_q)
        3'd0, 3'd2: mul_q <= $signed(alpha) * gyro_ang;
        3'd1, 3'd3: sum_q <= mul_q + $signed(beta) * bl_acc;
        default: ;
      endcase
    end
    if (out_load) begin
      mdata_q <= {angle_q[2][23:8], angle_q[1][23:8], angle_q[0][23:8]};
    end
  end

  `ACF_ASSERT(a_div_done, (state_q == acf_pkg::ST_BLEND) |-> !div_busy_q)
  `ACF_ASSERT(a_cdone_phase,
    cdone |-> (state_q == acf_pkg::ST_ROLL) || (state_q == acf_pkg::ST_PITCH))
  `ACF_ASSERT(a_accept_seq, accept |=> (state_q == acf_pkg::ST_SQRT))
  `ACF_ASSERT(a_roll_range,
    (26'(angle_q[0]) <= acf_pkg::HalfTurn) && (26'(angle_q[0]) >= -acf_pkg::HalfTurn))
  `ACF_ASSERT(a_yaw_range,
    (26'(angle_q[2]) <= acf_pkg::HalfTurn) && (26'(angle_q[2]) >= -acf_pkg::HalfTurn))

endmodule

// ===== hw/rtl/acf_cordic.sv =====
// ----------------------------------------------------------------------------
// Attitude filter CORDIC
// Iterative vectoring atan2, one micro-rotation per cycle, angle in 1/32768 deg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "attitude_complementary_filter_assert.svh"

module acf_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] y_i,
  input  logic signed [16:0] x_i,
  output logic               done_o,
  output logic signed [24:0] angle_o
);

  localparam int unsigned Steps   = (CORDIC_STEPS > acf_pkg::TabLen) ?
                                    acf_pkg::TabLen : CORDIC_STEPS;
  localparam logic [4:0]  LastIdx = 5'(Steps - 1);

  logic               run_q, done_q, zero_q;
  logic [4:0]         cnt_q;
  logic signed [32:0] x_q, y_q;
  logic signed [24:0] z_q;

  logic signed [32:0] xe, ye, xp, yp, xs, ys;
  logic signed [24:0] zp, tab;

  always_comb begin
    xe = 33'(x_i);
    ye = 33'(y_i);
    if (x_i < 0) begin
      if (y_i >= 0) begin
        xp = ye;
        yp = -xe;
        zp = acf_pkg::QuarterTurn;
      end else begin
        xp = -ye;
        yp = xe;
        zp = -acf_pkg::QuarterTurn;
      end
    end else begin
      xp = xe;
      yp = ye;
      zp = '0;
    end
    xs  = x_q >>> cnt_q;
    ys  = y_q >>> cnt_q;
    tab = $signed({4'd0, acf_pkg::acf_atan(cnt_q)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == LastIdx) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= xp <<< 14;
      y_q    <= yp <<< 14;
      z_q    <= zp;
      zero_q <= (x_i == 0) && (y_i == 0);
    end else if (run_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + tab;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - tab;
      end
    end
  end

  assign done_o  = done_q;
  assign angle_o = zero_q ? '0 : z_q;

  `ACF_ASSERT(a_start_idle, start_i |-> !run_q)
  `ACF_ASSERT(a_done_after_run, done_q |-> $past(run_q) && !run_q)
  `ACF_ASSERT(a_cnt_bound, run_q |-> cnt_q <= LastIdx)

endmodule
